// ===== hw/rtl/threshold_rule_relay_trigger_assert.svh =====
// Assertion macros used by the checker file of the rule trigger block.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef THRESHOLD_RULE_RELAY_TRIGGER_ASSERT_SVH
`define THRESHOLD_RULE_RELAY_TRIGGER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define TRRT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define TRRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/trrt_pkg.sv =====
// ----------------------------------------------------------------------------
// trrt_pkg
// Shared types and constants of the threshold rule relay trigger.
// ----------------------------------------------------------------------------
package trrt_pkg;

   localparam int unsigned ValueW   = 32;
   localparam int unsigned TimeW    = 32;
   localparam int unsigned SecW     = 16;
   localparam int unsigned MsW      = 26;
   localparam int unsigned ModeW    = 10;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned MsPerSec = 1000;
   localparam int unsigned EqTolLsb = 66;

   typedef enum logic [CsrIdxW-1:0] {
      RegRuleEnable  = 3'd0,
      RegRuleMode    = 3'd1,
      RegCond0First  = 3'd2,
      RegCond0Second = 3'd3,
      RegCond1First  = 3'd4,
      RegCond1Second = 3'd5,
      RegHold        = 3'd6,
      RegCooldown    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      OpGreater = 2'd0,
      OpLess    = 2'd1,
      OpBetween = 2'd2,
      OpEqual   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ActOn     = 2'd0,
      ActOff    = 2'd1,
      ActToggle = 2'd2,
      ActNone   = 2'd3
   } action_type;

   // Decoded rule configuration, shared by the front and the back.
   typedef struct packed {
      logic                     enable;
      op_type                   op0;
      op_type                   op1;
      logic                     cond1_used;
      logic                     logic_or;
      action_type               action;
      logic                     on_change;
      logic                     gate_used;
      logic signed [ValueW-1:0] c0_first;
      logic signed [ValueW-1:0] c0_second;
      logic signed [ValueW-1:0] c1_first;
      logic signed [ValueW-1:0] c1_second;
      logic [MsW-1:0]           hold_ms;
      logic [MsW-1:0]           cool_ms;
   } cfg_type;

   // Classified request handed from the front to the back.
   typedef struct packed {
      logic             invalid;
      logic             result;
      logic [TimeW-1:0] now_ms;
      logic             relay_level;
      logic             relay_present;
   } item_type;

endpackage

// ===== hw/rtl/threshold_rule_relay_trigger.sv =====
// ----------------------------------------------------------------------------
// threshold_rule_relay_trigger
// Evaluates one threshold automation rule per request and drives a relay.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Carries
//   req_     in         req_valid/req_ready    sensor values, flags, time, relay
//   rsp_     out        rsp_valid/rsp_ready    fire, drive level, status flags
//   csr_     in         csr_valid/csr_ready    register index and write data
//
// One request is taken every cycle while the queue has room; an accepted request
// is written into the queue and popped into the response register when the
// response side is free. The rate is set by the back stage, which updates the
// debounce and cooldown state once per popped request; the two-entry queue lets
// the front keep accepting while the response register is stalled, until full.
// Reset is synchronous and clears the rule state, the configuration and the
// response register to zero; the queue storage itself is not cleared.
// req_ready drops only when the queue holds two requests; csr_ready is always 1.
//
module threshold_rule_relay_trigger (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [trrt_pkg::ValueW-1:0] req_sensor0_value,
   input  logic                               req_sensor0_valid,
   input  logic signed [trrt_pkg::ValueW-1:0] req_sensor1_value,
   input  logic                               req_sensor1_valid,
   input  logic                               req_gate_open,
   input  logic [trrt_pkg::TimeW-1:0]         req_now_ms,
   input  logic                               req_relay_level,
   input  logic                               req_relay_present,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_fire,
   output logic                               rsp_drive_level,
   output logic                               rsp_combined_result,
   output logic                               rsp_suspend_event,
   output logic                               rsp_gate_disable_request,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [trrt_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [trrt_pkg::ValueW-1:0]        csr_data
);

   // Configuration registers. Hold and cooldown are stored already scaled to
   // milliseconds, so the back stage only subtracts and compares.
   logic                                enable_ff;
   logic [trrt_pkg::ModeW-1:0]          mode_ff;
   logic signed [trrt_pkg::ValueW-1:0]  c0_first_ff;
   logic signed [trrt_pkg::ValueW-1:0]  c0_second_ff;
   logic signed [trrt_pkg::ValueW-1:0]  c1_first_ff;
   logic signed [trrt_pkg::ValueW-1:0]  c1_second_ff;
   logic [trrt_pkg::MsW-1:0]            hold_ms_ff;
   logic [trrt_pkg::MsW-1:0]            cool_ms_ff;
   logic [trrt_pkg::MsW-1:0]            sec_to_ms_in;

   trrt_pkg::cfg_type       cfg;
   trrt_pkg::csr_index_type csr_sel;
   trrt_pkg::item_type      front_item;
   trrt_pkg::item_type      head_item;
   logic                    csr_write;
   logic                    queue_full;
   logic                    queue_not_empty;
   logic                    queue_pop;
   logic                    req_take;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_sel   = trrt_pkg::csr_index_type'(csr_index);

   // Seconds to milliseconds for the timing registers.
   assign sec_to_ms_in = trrt_pkg::MsW'(csr_data[trrt_pkg::SecW-1:0]) *
                         trrt_pkg::MsW'(trrt_pkg::MsPerSec);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         mode_ff      <= '0;
         c0_first_ff  <= '0;
         c0_second_ff <= '0;
         c1_first_ff  <= '0;
         c1_second_ff <= '0;
         hold_ms_ff   <= '0;
         cool_ms_ff   <= '0;
      end else if (csr_write) begin
         case (csr_sel)
            trrt_pkg::RegRuleEnable:  enable_ff    <= csr_data[0];
            trrt_pkg::RegRuleMode:    mode_ff      <= csr_data[trrt_pkg::ModeW-1:0];
            trrt_pkg::RegCond0First:  c0_first_ff  <= csr_data;
            trrt_pkg::RegCond0Second: c0_second_ff <= csr_data;
            trrt_pkg::RegCond1First:  c1_first_ff  <= csr_data;
            trrt_pkg::RegCond1Second: c1_second_ff <= csr_data;
            trrt_pkg::RegHold:        hold_ms_ff   <= sec_to_ms_in;
            trrt_pkg::RegCooldown:    cool_ms_ff   <= sec_to_ms_in;
            default: begin
            end
         endcase
      end
   end

   // Decode the mode word into the shared configuration structure.
   always_comb begin
      cfg.enable     = enable_ff;
      cfg.op0        = trrt_pkg::op_type'(mode_ff[1:0]);
      cfg.op1        = trrt_pkg::op_type'(mode_ff[3:2]);
      cfg.cond1_used = mode_ff[4];
      cfg.logic_or   = mode_ff[5];
      cfg.action     = trrt_pkg::action_type'(mode_ff[7:6]);
      cfg.on_change  = mode_ff[8];
      cfg.gate_used  = mode_ff[9];
      cfg.c0_first   = c0_first_ff;
      cfg.c0_second  = c0_second_ff;
      cfg.c1_first   = c1_first_ff;
      cfg.c1_second  = c1_second_ff;
      cfg.hold_ms    = hold_ms_ff;
      cfg.cool_ms    = cool_ms_ff;
   end

   // A request is accepted whenever the queue has room.
   assign req_ready = !queue_full;
   assign req_take  = req_valid && req_ready;

   trrt_front u_front (
      .cfg           (cfg),
      .sensor0_value (req_sensor0_value),
      .sensor0_valid (req_sensor0_valid),
      .sensor1_value (req_sensor1_value),
      .sensor1_valid (req_sensor1_valid),
      .gate_open     (req_gate_open),
      .now_ms        (req_now_ms),
      .relay_level   (req_relay_level),
      .relay_present (req_relay_present),
      .item          (front_item)
   );

   trrt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_not_empty),
      .head      (head_item)
   );

   // Any write of the enable register lifts a suspension.
   trrt_back u_back (
      .clock                    (clock),
      .reset                    (reset),
      .cfg                      (cfg),
      .suspend_clear            (csr_write && (csr_sel == trrt_pkg::RegRuleEnable)),
      .head_valid               (queue_not_empty),
      .head                     (head_item),
      .pop                      (queue_pop),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_fire                 (rsp_fire),
      .rsp_drive_level          (rsp_drive_level),
      .rsp_combined_result      (rsp_combined_result),
      .rsp_suspend_event        (rsp_suspend_event),
      .rsp_gate_disable_request (rsp_gate_disable_request)
   );

endmodule

// ===== hw/rtl/trrt_front.sv =====
// ----------------------------------------------------------------------------
// trrt_front
// Compares the sensor values with their thresholds, combines and gates the results.
// ----------------------------------------------------------------------------
module trrt_front (
   input  trrt_pkg::cfg_type                   cfg,
   input  logic signed [trrt_pkg::ValueW-1:0]  sensor0_value,
   input  logic                                sensor0_valid,
   input  logic signed [trrt_pkg::ValueW-1:0]  sensor1_value,
   input  logic                                sensor1_valid,
   input  logic                                gate_open,
   input  logic [trrt_pkg::TimeW-1:0]          now_ms,
   input  logic                                relay_level,
   input  logic                                relay_present,
   output trrt_pkg::item_type                  item
);

   function automatic logic compare_value(
      input trrt_pkg::op_type                  op,
      input logic signed [trrt_pkg::ValueW-1:0] live,
      input logic signed [trrt_pkg::ValueW-1:0] first,
      input logic signed [trrt_pkg::ValueW-1:0] second
   );
      logic signed [trrt_pkg::ValueW:0] diff;
      logic                             hit;
      diff = {live[trrt_pkg::ValueW-1], live} - {first[trrt_pkg::ValueW-1], first};
      case (op)
         trrt_pkg::OpGreater: hit = live > first;
         trrt_pkg::OpLess:    hit = live < first;
         trrt_pkg::OpBetween: hit = (live >= first) && (live <= second);
         trrt_pkg::OpEqual: begin
            hit = (diff < $signed((trrt_pkg::ValueW+1)'(trrt_pkg::EqTolLsb))) &&
                  (diff > -$signed((trrt_pkg::ValueW+1)'(trrt_pkg::EqTolLsb)));
         end
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   logic hit0;
   logic hit1;
   logic combined;
   logic gate;

   always_comb begin
      hit0 = compare_value(cfg.op0, sensor0_value, cfg.c0_first, cfg.c0_second);
      hit1 = compare_value(cfg.op1, sensor1_value, cfg.c1_first, cfg.c1_second);
      gate = cfg.gate_used ? gate_open : 1'b1;
      if (!cfg.cond1_used) begin
         combined = hit0;
      end else if (cfg.logic_or) begin
         combined = hit0 | hit1;
      end else begin
         combined = hit0 & hit1;
      end
      item.invalid       = !sensor0_valid || (cfg.cond1_used && !sensor1_valid);
      item.result        = gate & combined;
      item.now_ms        = now_ms;
      item.relay_level   = relay_level;
      item.relay_present = relay_present;
   end

endmodule

// ===== hw/rtl/trrt_queue.sv =====
// ----------------------------------------------------------------------------
// trrt_queue
// Two-entry queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module trrt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  trrt_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output trrt_pkg::item_type head
);

   trrt_pkg::item_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   always_comb begin
      full      = count_ff == 2'd2;
      not_empty = count_ff != 2'd0;
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/trrt_back.sv =====
// ----------------------------------------------------------------------------
// trrt_back
// Debounce, cooldown and suspension state; drives the response register.
// ----------------------------------------------------------------------------
module trrt_back (
   input  logic               clock,
   input  logic               reset,
   input  trrt_pkg::cfg_type  cfg,
   input  logic               suspend_clear,
   input  logic               head_valid,
   input  trrt_pkg::item_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_fire,
   output logic               rsp_drive_level,
   output logic               rsp_combined_result,
   output logic               rsp_suspend_event,
   output logic               rsp_gate_disable_request
);

   logic                         have_ff, have_in;
   logic                         stable_ff, stable_in;
   logic                         fired_ff, fired_in;
   logic                         susp_ff, susp_in;
   logic [trrt_pkg::TimeW-1:0]   since_ff, since_in;
   logic [trrt_pkg::TimeW-1:0]   last_ff, last_in;
   logic                         valid_ff, valid_in;
   logic                         fire_ff, fire_in;
   logic                         drive_ff, drive_in;
   logic                         comb_ff, comb_in;
   logic                         sevt_ff, sevt_in;
   logic                         gdr_ff, gdr_in;

   logic                         new_state;
   logic                         fired_cur;
   logic [trrt_pkg::TimeW-1:0]   since_cur;
   logic                         hold_wait;
   logic                         cool_wait;
   logic                         blocked;

   always_comb begin
      pop       = head_valid && (!valid_ff || rsp_ready);
      new_state = !have_ff || (head.result != stable_ff);
      since_cur = new_state ? head.now_ms : since_ff;
      fired_cur = new_state ? 1'b0 : fired_ff;
      hold_wait = (head.now_ms - since_cur) < trrt_pkg::TimeW'(cfg.hold_ms);
      cool_wait = (last_ff != '0) &&
                  ((head.now_ms - last_ff) < trrt_pkg::TimeW'(cfg.cool_ms));
      blocked   = (fired_cur && cfg.on_change) || hold_wait || cool_wait ||
                  !head.relay_present;

      have_in   = have_ff;
      stable_in = stable_ff;
      fired_in  = fired_ff;
      susp_in   = suspend_clear ? 1'b0 : susp_ff;
      since_in  = since_ff;
      last_in   = last_ff;
      valid_in  = pop ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      fire_in   = fire_ff;
      drive_in  = drive_ff;
      comb_in   = comb_ff;
      sevt_in   = sevt_ff;
      gdr_in    = gdr_ff;

      if (pop) begin
         fire_in  = 1'b0;
         drive_in = 1'b0;
         comb_in  = 1'b0;
         sevt_in  = 1'b0;
         gdr_in   = 1'b0;
         if (!cfg.enable || susp_ff || head.invalid) begin
            if (cfg.enable && !susp_ff && have_ff) begin
               susp_in = 1'b1;
               sevt_in = 1'b1;
               gdr_in  = cfg.gate_used;
            end
            have_in  = 1'b0;
            fired_in = 1'b0;
            since_in = '0;
         end else begin
            comb_in   = head.result;
            have_in   = 1'b1;
            stable_in = head.result;
            since_in  = since_cur;
            fired_in  = fired_cur;
            if (!blocked) begin
               last_in = head.now_ms;
               if (cfg.on_change) begin
                  fired_in = 1'b1;
               end
               case (cfg.action)
                  trrt_pkg::ActOn: begin
                     fire_in  = 1'b1;
                     drive_in = head.result;
                  end
                  trrt_pkg::ActOff: begin
                     fire_in  = 1'b1;
                     drive_in = !head.result;
                  end
                  trrt_pkg::ActToggle: begin
                     fire_in  = 1'b1;
                     drive_in = !head.relay_level;
                  end
                  default: begin
                     fire_in  = 1'b0;
                     drive_in = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff   <= 1'b0;
         stable_ff <= 1'b0;
         fired_ff  <= 1'b0;
         susp_ff   <= 1'b0;
         since_ff  <= '0;
         last_ff   <= '0;
         valid_ff  <= 1'b0;
         fire_ff   <= 1'b0;
         drive_ff  <= 1'b0;
         comb_ff   <= 1'b0;
         sevt_ff   <= 1'b0;
         gdr_ff    <= 1'b0;
      end else begin
         have_ff   <= have_in;
         stable_ff <= stable_in;
         fired_ff  <= fired_in;
         susp_ff   <= susp_in;
         since_ff  <= since_in;
         last_ff   <= last_in;
         valid_ff  <= valid_in;
         fire_ff   <= fire_in;
         drive_ff  <= drive_in;
         comb_ff   <= comb_in;
         sevt_ff   <= sevt_in;
         gdr_ff    <= gdr_in;
      end
   end

   assign rsp_valid                = valid_ff;
   assign rsp_fire                 = fire_ff;
   assign rsp_drive_level          = drive_ff;
   assign rsp_combined_result      = comb_ff;
   assign rsp_suspend_event        = sevt_ff;
   assign rsp_gate_disable_request = gdr_ff;

endmodule

// ===== hw/rtl/trrt_checker.sv =====
// ----------------------------------------------------------------------------
// trrt_checker
// Port-level checks of the rule trigger, bound to the top level.
// ----------------------------------------------------------------------------
`include "threshold_rule_relay_trigger_assert.svh"

module trrt_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_fire,
   input logic rsp_drive_level,
   input logic rsp_combined_result,
   input logic rsp_suspend_event,
   input logic rsp_gate_disable_request
);

   `TRRT_ASSERT_NOW(a_drive_needs_fire, clock, reset, rsp_valid && rsp_drive_level, rsp_fire, "drive level set without fire")
   `TRRT_ASSERT_NOW(a_suspend_quiet, clock, reset, rsp_valid && rsp_suspend_event, !rsp_fire && !rsp_combined_result, "suspension with fire or result")
   `TRRT_ASSERT_NOW(a_gate_req_needs_suspend, clock, reset, rsp_valid && rsp_gate_disable_request, rsp_suspend_event, "gate disable without suspension")
   `TRRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fire) && $stable(rsp_suspend_event), "stalled response changed")

endmodule

bind threshold_rule_relay_trigger trrt_checker u_trrt_checker (.*);

// ===== verif/tb_threshold_rule_relay_trigger.sv =====
// ----------------------------------------------------------------------------
// tb_threshold_rule_relay_trigger
// Self-checking bench for the threshold rule relay trigger.
// Requests are predicted one by one against a behavioral copy of the rule
// (compare, combine, gate, debounce, cooldown, suspension), then compared
// field by field with every response the block hands back.
// ----------------------------------------------------------------------------
module tb_threshold_rule_relay_trigger;

   timeunit 1ns;
   timeprecision 1ps;

   // The bench fails on its own if no handshake of any kind completes for
   // this many cycles. The longest legal quiet stretch is a long receiver
   // stall on each of a few responses in flight, well under this.
   localparam int unsigned QuietLimit = 2000;
   localparam int unsigned RandomRequests = 1630;

   localparam logic signed [trrt_pkg::ValueW-1:0] MinValue = 32'sh8000_0000;
   localparam logic signed [trrt_pkg::ValueW-1:0] MaxValue = 32'sh7FFF_FFFF;
   localparam logic signed [trrt_pkg::ValueW-1:0] OneQ16 = 32'sh0001_0000;

   // One sensor request as queued for the driver. The hold-off flag makes
   // the driver wait until every earlier response has come back.
   typedef struct {
      logic signed [trrt_pkg::ValueW-1:0] s0_value;
      logic                               s0_ok;
      logic signed [trrt_pkg::ValueW-1:0] s1_value;
      logic                               s1_ok;
      logic                               gate_open;
      logic [trrt_pkg::TimeW-1:0]         now_ms;
      logic                               relay_level;
      logic                               relay_present;
      logic                               hold_off;
   } reading_type;

   // One expected response.
   typedef struct packed {
      logic fire;
      logic drive_level;
      logic combined_result;
      logic suspend_event;
      logic gate_disable_request;
   } rule_outcome_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic signed [trrt_pkg::ValueW-1:0] req_sensor0_value = '0;
   logic                               req_sensor0_valid = 1'b0;
   logic signed [trrt_pkg::ValueW-1:0] req_sensor1_value = '0;
   logic                               req_sensor1_valid = 1'b0;
   logic                               req_gate_open = 1'b0;
   logic [trrt_pkg::TimeW-1:0]         req_now_ms = '0;
   logic                               req_relay_level = 1'b0;
   logic                               req_relay_present = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_fire;
   logic                               rsp_drive_level;
   logic                               rsp_combined_result;
   logic                               rsp_suspend_event;
   logic                               rsp_gate_disable_request;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [trrt_pkg::CsrIdxW-1:0]       csr_index = '0;
   logic [trrt_pkg::ValueW-1:0]        csr_data = '0;

   // Pending requests (filled by the stimulus) and expected responses
   // (filled by the prediction in the monitor).
   reading_type      reading_q[$];
   rule_outcome_type outcome_q[$];
   int unsigned      mismatches = 0;

   // Configuration copy, reset values.
   logic                               rule_on = 1'b0;
   logic [trrt_pkg::ModeW-1:0]         mode_bits = '0;
   logic signed [trrt_pkg::ValueW-1:0] c0_first = '0;
   logic signed [trrt_pkg::ValueW-1:0] c0_second = '0;
   logic signed [trrt_pkg::ValueW-1:0] c1_first = '0;
   logic signed [trrt_pkg::ValueW-1:0] c1_second = '0;
   logic [trrt_pkg::SecW-1:0]          hold_sec = '0;
   logic [trrt_pkg::SecW-1:0]          cool_sec = '0;

   // Rule state copy, reset values. A last firing time of zero reads as
   // "never fired", exactly as in the block.
   logic                       has_verdict = 1'b0;
   logic                       held_verdict = 1'b0;
   logic                       fired_in_state = 1'b0;
   logic                       rule_suspended = 1'b0;
   logic [trrt_pkg::TimeW-1:0] verdict_since_ms = '0;
   logic [trrt_pkg::TimeW-1:0] last_fire_ms = '0;

   // Driver and monitor bookkeeping.
   reading_type      next_reading;
   rule_outcome_type seen_outcome;
   rule_outcome_type want_outcome;
   int unsigned      sender_gap = 0;
   int unsigned      receiver_gap = 0;
   int unsigned      in_flight = 0;
   int unsigned      sender_ticks = 0;
   int unsigned      receiver_ticks = 0;
   int unsigned      quiet_cycles = 0;
   logic             sender_calm = 1'b0;
   logic             receiver_calm = 1'b0;

   threshold_rule_relay_trigger uut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_sensor0_value        (req_sensor0_value),
      .req_sensor0_valid        (req_sensor0_valid),
      .req_sensor1_value        (req_sensor1_value),
      .req_sensor1_valid        (req_sensor1_valid),
      .req_gate_open            (req_gate_open),
      .req_now_ms               (req_now_ms),
      .req_relay_level          (req_relay_level),
      .req_relay_present        (req_relay_present),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_fire                 (rsp_fire),
      .rsp_drive_level          (rsp_drive_level),
      .rsp_combined_result      (rsp_combined_result),
      .rsp_suspend_event        (rsp_suspend_event),
      .rsp_gate_disable_request (rsp_gate_disable_request),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // One threshold comparison. Equality is a tolerance band, evaluated on the
   // 64-bit difference so that opposite extremes cannot wrap into the band.
   function automatic logic meets(trrt_pkg::op_type op,
                                  logic signed [trrt_pkg::ValueW-1:0] live,
                                  logic signed [trrt_pkg::ValueW-1:0] first,
                                  logic signed [trrt_pkg::ValueW-1:0] second);
      longint span;
      case (op)
         trrt_pkg::OpGreater: return live > first;
         trrt_pkg::OpLess:    return live < first;
         trrt_pkg::OpBetween: return (live >= first) && (live <= second);
         default: begin
            span = longint'(live) - longint'(first);
            if (span < 0) span = -span;
            return span < longint'(trrt_pkg::EqTolLsb);
         end
      endcase
   endfunction

   // Drops the debounce state. The last firing time is kept on purpose, so
   // the cooldown survives a disabled or suspended rule.
   function automatic void forget_verdict();
      has_verdict = 1'b0;
      fired_in_state = 1'b0;
      verdict_since_ms = '0;
   endfunction

   // Works out the response to one accepted request and advances the rule
   // state the way the block is meant to.
   function automatic rule_outcome_type evaluate_rule(
         logic signed [trrt_pkg::ValueW-1:0] s0_value, logic s0_ok,
         logic signed [trrt_pkg::ValueW-1:0] s1_value, logic s1_ok,
         logic gate_open, logic [trrt_pkg::TimeW-1:0] now_ms,
         logic relay_level, logic relay_present);
      rule_outcome_type           outcome;
      logic                       c1_used;
      logic                       use_or;
      logic                       on_change;
      logic                       gate_used;
      logic                       verdict;
      logic                       c1_hit;
      trrt_pkg::action_type       action;
      logic [trrt_pkg::TimeW-1:0] hold_ms;
      logic [trrt_pkg::TimeW-1:0] cool_ms;
      logic [trrt_pkg::TimeW-1:0] age_ms;

      outcome = '0;
      c1_used = mode_bits[4];
      use_or = mode_bits[5];
      action = trrt_pkg::action_type'(mode_bits[7:6]);
      on_change = mode_bits[8];
      gate_used = mode_bits[9];
      hold_ms = trrt_pkg::TimeW'(hold_sec) * trrt_pkg::MsPerSec;
      cool_ms = trrt_pkg::TimeW'(cool_sec) * trrt_pkg::MsPerSec;

      if (!rule_on || rule_suspended) begin
         forget_verdict();
         return outcome;
      end

      // A missing sensor only suspends a rule that already had a verdict.
      if (!s0_ok || (c1_used && !s1_ok)) begin
         if (has_verdict) begin
            rule_suspended = 1'b1;
            outcome.suspend_event = 1'b1;
            outcome.gate_disable_request = gate_used;
         end
         forget_verdict();
         return outcome;
      end

      // A used gate that is closed forces the verdict low.
      verdict = 1'b0;
      if (!gate_used || gate_open) begin
         verdict = meets(trrt_pkg::op_type'(mode_bits[1:0]), s0_value, c0_first, c0_second);
         if (c1_used) begin
            c1_hit = meets(trrt_pkg::op_type'(mode_bits[3:2]), s1_value, c1_first,
                           c1_second);
            verdict = use_or ? (verdict | c1_hit) : (verdict & c1_hit);
         end
      end
      outcome.combined_result = verdict;

      // A new or changed verdict restarts the debounce window.
      if (!has_verdict || (verdict != held_verdict)) begin
         has_verdict = 1'b1;
         held_verdict = verdict;
         verdict_since_ms = now_ms;
         fired_in_state = 1'b0;
      end

      if (fired_in_state && on_change) return outcome;
      age_ms = now_ms - verdict_since_ms;
      if (age_ms < hold_ms) return outcome;
      age_ms = now_ms - last_fire_ms;
      if ((last_fire_ms != '0) && (age_ms < cool_ms)) return outcome;
      if (!relay_present) return outcome;

      // Action "none" still books the firing time and the on-change latch.
      case (action)
         trrt_pkg::ActOn: begin
            outcome.fire = 1'b1;
            outcome.drive_level = verdict;
         end
         trrt_pkg::ActOff: begin
            outcome.fire = 1'b1;
            outcome.drive_level = !verdict;
         end
         trrt_pkg::ActToggle: begin
            outcome.fire = 1'b1;
            outcome.drive_level = !relay_level;
         end
         default: ;
      endcase
      last_fire_ms = now_ms;
      if (on_change) fired_in_state = 1'b1;
      return outcome;
   endfunction

   // Mirrors one register write into the configuration copy. Any write of the
   // enable register lifts a suspension.
   function automatic void apply_register(trrt_pkg::csr_index_type idx,
                                          logic [trrt_pkg::ValueW-1:0] data);
      case (idx)
         trrt_pkg::RegRuleEnable: begin
            rule_on = data[0];
            rule_suspended = 1'b0;
         end
         trrt_pkg::RegRuleMode:    mode_bits = data[trrt_pkg::ModeW-1:0];
         trrt_pkg::RegCond0First:  c0_first = data;
         trrt_pkg::RegCond0Second: c0_second = data;
         trrt_pkg::RegCond1First:  c1_first = data;
         trrt_pkg::RegCond1Second: c1_second = data;
         trrt_pkg::RegHold:        hold_sec = data[trrt_pkg::SecW-1:0];
         trrt_pkg::RegCooldown:    cool_sec = data[trrt_pkg::SecW-1:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Gap lengths: mostly none or short, now and then a long one. In a calm
   // stretch there are no gaps at all.
   function automatic int unsigned pick_gap(logic calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [trrt_pkg::ModeW-1:0] mode_word(
         trrt_pkg::op_type op0, trrt_pkg::op_type op1, logic c1_used, logic use_or,
         trrt_pkg::action_type action, logic on_change, logic gate_used);
      return {gate_used, on_change, action, use_or, c1_used, op1, op0};
   endfunction

   function automatic logic signed [trrt_pkg::ValueW-1:0] pick_threshold();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 5) return MinValue;
      if (r < 10) return MaxValue;
      if (r < 60) return 32'($urandom_range(0, 1 << 21)) - 32'h0010_0000;
      return $urandom();
   endfunction

   // Sensor values cluster around the thresholds, including the edges of the
   // equality band, with some spread, full-range values and the extremes.
   function automatic logic signed [trrt_pkg::ValueW-1:0] pick_sensor(
         logic signed [trrt_pkg::ValueW-1:0] lo, logic signed [trrt_pkg::ValueW-1:0] hi);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30) return lo + 32'($urandom_range(0, 140)) - 32'd70;
      if (r < 45) return hi + 32'($urandom_range(0, 140)) - 32'd70;
      if (r < 65) return lo + 32'($urandom_range(0, 1 << 21)) - 32'h0010_0000;
      if (r < 92) return $urandom();
      if (r < 96) return MinValue;
      return MaxValue;
   endfunction

   function automatic logic [trrt_pkg::SecW-1:0] pick_seconds();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 15) return '0;
      if (r < 65) return trrt_pkg::SecW'($urandom_range(1, 2));
      if (r < 90) return trrt_pkg::SecW'($urandom_range(3, 10));
      if (r < 97) return trrt_pkg::SecW'($urandom_range(0, 65535));
      return 16'hFFFF;
   endfunction

   // Time advance between ticks: usually under a couple of seconds, at times
   // long enough to satisfy the largest hold, rarely an arbitrary jump.
   function automatic logic [trrt_pkg::TimeW-1:0] pick_step_ms();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 80) return $urandom_range(1, 1500);
      if (r < 95) return $urandom_range(1500, 10000);
      if (r < 99) return $urandom_range(0, 70000000);
      return $urandom();
   endfunction

   task automatic add_reading(logic signed [trrt_pkg::ValueW-1:0] s0_value, logic s0_ok,
                              logic signed [trrt_pkg::ValueW-1:0] s1_value, logic s1_ok,
                              logic gate_open, logic [trrt_pkg::TimeW-1:0] now_ms,
                              logic relay_level, logic relay_present, logic hold_off);
      reading_type item;
      item.s0_value = s0_value;
      item.s0_ok = s0_ok;
      item.s1_value = s1_value;
      item.s1_ok = s1_ok;
      item.gate_open = gate_open;
      item.now_ms = now_ms;
      item.relay_level = relay_level;
      item.relay_present = relay_present;
      item.hold_off = hold_off;
      reading_q.push_back(item);
   endtask

   // Waits, looking at settled values on the falling edge, until every queued
   // request is sent and every response is back, then lets a few cycles pass.
   // Returns on a rising edge.
   task automatic wait_quiet();
      do @(negedge clock);
      while (reading_q.size() != 0 || req_valid || outcome_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // One register write. Valid stays high into the next write of a batch; the
   // caller lowers it after the last one.
   task automatic write_register(trrt_pkg::csr_index_type idx,
                                 logic [trrt_pkg::ValueW-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      apply_register(idx, data);
   endtask

   // Loads a whole rule while the block is idle, then returns on a falling
   // edge so the caller can queue requests without racing the driver.
   task automatic program_rule(logic enable, logic [trrt_pkg::ModeW-1:0] mode,
                               logic signed [trrt_pkg::ValueW-1:0] f0,
                               logic signed [trrt_pkg::ValueW-1:0] s0,
                               logic signed [trrt_pkg::ValueW-1:0] f1,
                               logic signed [trrt_pkg::ValueW-1:0] s1,
                               logic [trrt_pkg::SecW-1:0] hold,
                               logic [trrt_pkg::SecW-1:0] cool);
      wait_quiet();
      write_register(trrt_pkg::RegRuleEnable, trrt_pkg::ValueW'(enable));
      write_register(trrt_pkg::RegRuleMode, trrt_pkg::ValueW'(mode));
      write_register(trrt_pkg::RegCond0First, f0);
      write_register(trrt_pkg::RegCond0Second, s0);
      write_register(trrt_pkg::RegCond1First, f1);
      write_register(trrt_pkg::RegCond1Second, s1);
      write_register(trrt_pkg::RegHold, trrt_pkg::ValueW'(hold));
      write_register(trrt_pkg::RegCooldown, trrt_pkg::ValueW'(cool));
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_field(string field, logic want, logic got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
         mismatches++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents queued requests, with random gaps between them. A
   // request marked for hold-off is not presented until all responses for
   // earlier requests have been taken.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // In-flight count from this edge's handshakes, both sampled before
         // the edge, so it never depends on the monitor's ordering.
         if (req_valid && req_ready) in_flight++;
         if (rsp_valid && rsp_ready) in_flight--;

         sender_ticks++;
         if (sender_ticks % 256 == 0) sender_calm = ($urandom_range(0, 3) == 0);

         // A new request may go out once the current one has been accepted.
         if (!req_valid || req_ready) begin
            if (sender_gap != 0) begin
               sender_gap--;
               req_valid <= 1'b0;
            end else if (reading_q.size() != 0 &&
                         !(reading_q[0].hold_off && in_flight != 0)) begin
               next_reading = reading_q.pop_front();
               req_sensor0_value <= next_reading.s0_value;
               req_sensor0_valid <= next_reading.s0_ok;
               req_sensor1_value <= next_reading.s1_value;
               req_sensor1_valid <= next_reading.s1_ok;
               req_gate_open <= next_reading.gate_open;
               req_now_ms <= next_reading.now_ms;
               req_relay_level <= next_reading.relay_level;
               req_relay_present <= next_reading.relay_present;
               req_valid <= 1'b1;
               sender_gap = pick_gap(sender_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each response against the oldest expectation first and
   // only then predicts the request accepted on the same edge, so a response
   // can never be matched against its own request's prediction. It also
   // drives the response-side stalls.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_outcome = {rsp_fire, rsp_drive_level, rsp_combined_result,
                            rsp_suspend_event, rsp_gate_disable_request};
            if (outcome_q.size() == 0) begin
               $display("%0t ns: response mismatch, expected none, actual %b",
                        $time, seen_outcome);
               mismatches++;
            end else begin
               want_outcome = outcome_q.pop_front();
               check_field("fire", want_outcome.fire, rsp_fire);
               check_field("drive_level", want_outcome.drive_level, rsp_drive_level);
               check_field("combined_result", want_outcome.combined_result,
                           rsp_combined_result);
               check_field("suspend_event", want_outcome.suspend_event, rsp_suspend_event);
               check_field("gate_disable_request", want_outcome.gate_disable_request,
                           rsp_gate_disable_request);
            end
         end

         if (req_valid && req_ready) begin
            outcome_q.push_back(evaluate_rule(req_sensor0_value, req_sensor0_valid,
                                              req_sensor1_value, req_sensor1_valid,
                                              req_gate_open, req_now_ms,
                                              req_relay_level, req_relay_present));
         end

         receiver_ticks++;
         if (receiver_ticks % 256 == 128) receiver_calm = ($urandom_range(0, 3) == 0);
         if (receiver_gap != 0) begin
            receiver_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            receiver_gap = pick_gap(receiver_calm);
         end
      end
   end

   // Watchdog: any completed handshake counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus: a directed part, then random rules, each with a run of
   // requests whose values mostly persist so the debounce can settle.
   // ------------------------------------------------------------------------
   initial begin
      int unsigned                        random_count;
      int unsigned                        run_len;
      int unsigned                        i;
      logic                               enable;
      logic [trrt_pkg::ModeW-1:0]         mode;
      logic signed [trrt_pkg::ValueW-1:0] f0;
      logic signed [trrt_pkg::ValueW-1:0] s0;
      logic signed [trrt_pkg::ValueW-1:0] f1;
      logic signed [trrt_pkg::ValueW-1:0] s1;
      logic signed [trrt_pkg::ValueW-1:0] v0;
      logic signed [trrt_pkg::ValueW-1:0] v1;
      logic                               ok0;
      logic                               ok1;
      logic                               gate;
      logic [trrt_pkg::TimeW-1:0]         wall_ms;

      random_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Equality on sensor 0 AND a between window on sensor 1, toggle action,
      // on-change, gate used, no hold and no cooldown. The first firing lands
      // at time zero, which still reads as never fired.
      program_rule(1'b1, mode_word(trrt_pkg::OpEqual, trrt_pkg::OpBetween, 1'b1, 1'b0,
                                   trrt_pkg::ActToggle, 1'b1, 1'b1),
                   OneQ16, '0, -32'sd100, 32'sd100, '0, '0);
      add_reading(OneQ16 + 32'sd65, 1'b1, '0, 1'b1, 1'b1, 32'd0, 1'b0, 1'b1, 1'b0);
      add_reading(OneQ16 - 32'sd65, 1'b1, '0, 1'b1, 1'b1, 32'd0, 1'b1, 1'b1, 1'b0);
      add_reading(OneQ16 + 32'sd66, 1'b1, '0, 1'b1, 1'b1, 32'd5, 1'b1, 1'b1, 1'b0);
      add_reading(OneQ16 - 32'sd66, 1'b1, '0, 1'b1, 1'b1, 32'd10, 1'b0, 1'b1, 1'b0);
      // Gate closed: the verdict is forced low even though both conditions hold.
      add_reading(OneQ16, 1'b1, '0, 1'b1, 1'b0, 32'd15, 1'b0, 1'b1, 1'b0);
      // Window edges, the first sent only once everything earlier has drained.
      add_reading(OneQ16, 1'b1, -32'sd100, 1'b1, 1'b1, 32'd20, 1'b1, 1'b1, 1'b1);
      add_reading(OneQ16, 1'b1, 32'sd100, 1'b1, 1'b1, 32'd25, 1'b0, 1'b1, 1'b0);
      add_reading(OneQ16, 1'b1, 32'sd101, 1'b1, 1'b1, 32'd30, 1'b1, 1'b1, 1'b0);
      add_reading(MaxValue, 1'b1, MinValue, 1'b1, 1'b1, 32'd35, 1'b0, 1'b1, 1'b0);
      // Relay absent: a true verdict with nothing to drive.
      add_reading(OneQ16, 1'b1, '0, 1'b1, 1'b1, 32'd40, 1'b0, 1'b0, 1'b0);
      // Sensor 1 missing while a verdict exists: suspend with gate disable.
      add_reading(OneQ16, 1'b1, '0, 1'b0, 1'b1, 32'd45, 1'b0, 1'b1, 1'b0);
      add_reading(OneQ16, 1'b1, '0, 1'b1, 1'b1, 32'd50, 1'b0, 1'b1, 1'b0);

      // Greater than the minimum, sensor 1 and gate unused, action none, the
      // largest hold and cooldown, and time differences across the wrap.
      program_rule(1'b1, mode_word(trrt_pkg::OpGreater, trrt_pkg::OpLess, 1'b0, 1'b0,
                                   trrt_pkg::ActNone, 1'b0, 1'b0),
                   MinValue, MaxValue, MaxValue, MinValue, 16'hFFFF, 16'hFFFF);
      add_reading(MaxValue, 1'b0, '0, 1'b1, 1'b1, 32'd500, 1'b0, 1'b1, 1'b0);
      add_reading(MinValue, 1'b1, '0, 1'b0, 1'b0, 32'd1000, 1'b0, 1'b1, 1'b0);
      add_reading(MaxValue, 1'b1, '0, 1'b0, 1'b1, 32'd2000, 1'b0, 1'b1, 1'b0);
      add_reading(MaxValue, 1'b1, '0, 1'b0, 1'b0, 32'd65537000, 1'b1, 1'b1, 1'b0);
      add_reading('0, 1'b1, '0, 1'b1, 1'b1, 32'd65538000, 1'b0, 1'b1, 1'b0);
      add_reading('0, 1'b1, MaxValue, 1'b1, 1'b0, 32'hFFFF_FF00, 1'b1, 1'b1, 1'b0);
      add_reading('0, 1'b1, MinValue, 1'b0, 1'b1, 32'h0000_0100, 1'b0, 1'b1, 1'b0);

      // Rule disabled: every output stays low.
      program_rule(1'b0, mode_word(trrt_pkg::OpLess, trrt_pkg::OpGreater, 1'b1, 1'b1,
                                   trrt_pkg::ActOn, 1'b0, 1'b0),
                   '0, '0, '0, '0, '0, '0);
      add_reading(MinValue, 1'b1, MaxValue, 1'b1, 1'b1, 32'd100, 1'b1, 1'b1, 1'b0);

      // Less OR equal with the off action.
      program_rule(1'b1, mode_word(trrt_pkg::OpLess, trrt_pkg::OpEqual, 1'b1, 1'b1,
                                   trrt_pkg::ActOff, 1'b0, 1'b0),
                   '0, '0, '0, '0, '0, '0);
      add_reading(-32'sd1, 1'b1, 32'sd500, 1'b1, 1'b0, 32'd200, 1'b0, 1'b1, 1'b0);
      add_reading(32'sd5, 1'b1, 32'sd100, 1'b1, 1'b1, 32'd300, 1'b1, 1'b1, 1'b0);

      // Random rules; every request counts, including those to a disabled rule.
      wall_ms = $urandom();
      while (random_count < RandomRequests) begin
         enable = ($urandom_range(0, 9) != 0);
         mode = trrt_pkg::ModeW'($urandom());
         f0 = pick_threshold();
         f1 = pick_threshold();
         s0 = ($urandom_range(0, 4) == 0) ? pick_threshold()
                                          : f0 + 32'($urandom_range(0, 1 << 20));
         s1 = ($urandom_range(0, 4) == 0) ? pick_threshold()
                                          : f1 + 32'($urandom_range(0, 1 << 20));
         program_rule(enable, mode, f0, s0, f1, s1, pick_seconds(), pick_seconds());

         // Now and then restart the clock somewhere random or just before the wrap.
         if ($urandom_range(0, 9) == 0) begin
            wall_ms = ($urandom_range(0, 1) != 0) ? $urandom()
                                                  : 32'hFFFF_F000 + $urandom_range(0, 4095);
         end
         v0 = pick_sensor(f0, s0);
         v1 = pick_sensor(f1, s1);
         gate = 1'($urandom_range(0, 1));
         run_len = $urandom_range(20, 90);
         for (i = 0; i < run_len; i++) begin
            if ($urandom_range(0, 4) == 0) v0 = pick_sensor(f0, s0);
            if ($urandom_range(0, 4) == 0) v1 = pick_sensor(f1, s1);
            if ($urandom_range(0, 9) == 0) gate = !gate;
            wall_ms = wall_ms + pick_step_ms();
            ok0 = ($urandom_range(0, 199) != 0);
            ok1 = ($urandom_range(0, 149) != 0);
            // Some runs end with a missing sensor to exercise suspension.
            if (i == run_len - 1 && $urandom_range(0, 3) == 0) begin
               if ($urandom_range(0, 1) != 0) ok0 = 1'b0;
               else ok1 = 1'b0;
            end
            add_reading(v0, ok0, v1, ok1, gate, wall_ms, 1'($urandom_range(0, 1)),
                        $urandom_range(0, 19) != 0, $urandom_range(0, 59) == 0);
            random_count++;
         end
      end

      // Drain everything, give the block a few more cycles, then report.
      wait_quiet();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
